// ===== rtl/hsvrgb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// shared types and constants of the hsv to rgb pixel pipeline
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int unsigned HUE_W  = 9;
	localparam int unsigned PCT_W  = 7;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned OFFS_W = 6;
	localparam int unsigned PROD_W = 14;
	localparam int unsigned FIX_W  = 28;
	localparam int unsigned RED_W  = 22;
	localparam int unsigned RECIP_W = 23;
	localparam int unsigned MUL_W  = RED_W + RECIP_W;

	localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd100;
	localparam logic [HUE_W-1:0]   SECTOR_DEG = 9'd60;
	localparam logic [FIX_W-1:0]   HI_SCALE   = 28'd1530000;
	localparam logic [FIX_W-1:0]   LO_SCALE   = 28'd15300;
	localparam logic [FIX_W-1:0]   RAMP_SCALE = 28'd255;
	localparam int unsigned        DIV_SHIFT  = 6;
	localparam logic [RECIP_W-1:0] RECIP_M    = 23'd7330078;
	localparam int unsigned        RECIP_SHIFT = 36;

	typedef enum logic [2:0] {
		SEC_RED_GREEN_UP   = 3'd0,
		SEC_GREEN_RED_DOWN = 3'd1,
		SEC_GREEN_BLUE_UP  = 3'd2,
		SEC_BLUE_GREEN_DOWN = 3'd3,
		SEC_BLUE_RED_UP    = 3'd4,
		SEC_RED_BLUE_DOWN  = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t             sector;
		logic [OFFS_W-1:0]   offs;
		logic [PCT_W-1:0]    v;
		logic [PROD_W-1:0]   vs;
		logic [PROD_W-1:0]   vc;
	} split_t;

	typedef struct packed {
		sector_t            sector;
		logic [FIX_W-1:0]   hi;
		logic [FIX_W-1:0]   lo;
		logic [FIX_W-1:0]   ramp;
	} span_t;

	typedef struct packed {
		logic [RED_W-1:0] r;
		logic [RED_W-1:0] g;
		logic [RED_W-1:0] b;
	} mix_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] x);
		return (x > PCT_MAX) ? PCT_MAX : x;
	endfunction

endpackage : hsvrgb_pkg
`default_nettype wire

// ===== rtl/hsvrgb_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsvrgb interfaces
// valid/ready channels for hsv input items and rgb result items
// ----------------------------------------------------------------------------
interface hsvrgb_in_if;
	logic       valid;
	logic       ready;
	logic [8:0] hue;
	logic [6:0] saturation;
	logic [6:0] brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface : hsvrgb_in_if

interface hsvrgb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface : hsvrgb_out_if
`default_nettype wire

// ===== rtl/hsv_to_rgb_pixel_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_unit
// converts one hsv item to 8-bit red, green and blue per unstalled clock
// four register stages (split, span, mix, scale) from accepted item to result
// throughput: one item per cycle while the output is not stalled; each stage
// holds one item and refills as soon as its successor takes its item
// reset: arst_n clears the stage valid bits only; data registers are not reset
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_unit
	import hsvrgb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	hsvrgb_in_if.sink       in_item,
	hsvrgb_out_if.source    out_item
);

	logic   v1, v2, v3;
	logic   r1, r2, r3;
	split_t d1;
	span_t  d2;
	mix_t   d3;
	rgb_t   d4;

	hsvrgb_split u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (in_item.valid),
		.up_ready   (in_item.ready),
		.hue        (in_item.hue),
		.saturation (in_item.saturation),
		.brightness (in_item.brightness),
		.dn_valid   (v1),
		.dn_ready   (r1),
		.dn_data    (d1)
	);

	hsvrgb_span u_span (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v1),
		.up_ready (r1),
		.up_data  (d1),
		.dn_valid (v2),
		.dn_ready (r2),
		.dn_data  (d2)
	);

	hsvrgb_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v2),
		.up_ready (r2),
		.up_data  (d2),
		.dn_valid (v3),
		.dn_ready (r3),
		.dn_data  (d3)
	);

	hsvrgb_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v3),
		.up_ready (r3),
		.up_data  (d3),
		.dn_valid (out_item.valid),
		.dn_ready (out_item.ready),
		.dn_data  (d4)
	);

	assign out_item.red   = d4.red;
	assign out_item.green = d4.green;
	assign out_item.blue  = d4.blue;

endmodule : hsv_to_rgb_pixel_unit
`default_nettype wire

// ===== rtl/hsvrgb_split.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsvrgb_split
// stage 1: clamps inputs, splits hue into sector and offset, small products
// ----------------------------------------------------------------------------
module hsvrgb_split
	import hsvrgb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              up_valid,
	output logic                   up_ready,
	input  wire logic [HUE_W-1:0]  hue,
	input  wire logic [PCT_W-1:0]  saturation,
	input  wire logic [PCT_W-1:0]  brightness,
	output logic                   dn_valid,
	input  wire logic              dn_ready,
	output split_t                 dn_data
);

	logic              valid_s1;
	split_t            data_s1;
	split_t            next_data;
	logic [PCT_W-1:0]  s_c;
	logic [PCT_W-1:0]  v_c;
	logic [3:0]        quot;
	logic [HUE_W-1:0]  base;

	always_comb begin
		s_c  = clamp_pct(saturation);
		v_c  = clamp_pct(brightness);
		quot = 4'd0;
		for (int i = 1; i < 9; i++) begin
			if (hue >= HUE_W'(i) * SECTOR_DEG) begin
				quot = 4'(i);
			end
		end
		base = HUE_W'(quot) * SECTOR_DEG;
		next_data.offs   = OFFS_W'(hue - base);
		next_data.sector = (quot > 4'd5) ? SEC_RED_BLUE_DOWN : sector_t'(quot[2:0]);
		next_data.v      = v_c;
		next_data.vs     = PROD_W'(v_c) * PROD_W'(s_c);
		next_data.vc     = PROD_W'(v_c) * PROD_W'(PCT_MAX - s_c);
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= next_data;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule : hsvrgb_split
`default_nettype wire

// ===== rtl/hsvrgb_span.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsvrgb_span
// stage 2: max, min and ramp in units of 1/600000 of a channel step
// ----------------------------------------------------------------------------
module hsvrgb_span
	import hsvrgb_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    up_valid,
	output logic         up_ready,
	input  wire split_t  up_data,
	output logic         dn_valid,
	input  wire logic    dn_ready,
	output span_t        dn_data
);

	logic       valid_s2;
	span_t      data_s2;
	span_t      next_data;
	logic [19:0] vso;

	always_comb begin
		vso              = 20'(up_data.vs) * 20'(up_data.offs);
		next_data.sector = up_data.sector;
		next_data.hi     = FIX_W'(up_data.v) * HI_SCALE;
		next_data.lo     = FIX_W'(up_data.vc) * LO_SCALE;
		next_data.ramp   = FIX_W'(vso) * RAMP_SCALE;
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s2 <= next_data;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

endmodule : hsvrgb_span
`default_nettype wire

// ===== rtl/hsvrgb_mix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsvrgb_mix
// stage 3: rising and falling edges, per-sector channel selection
// ----------------------------------------------------------------------------
module hsvrgb_mix
	import hsvrgb_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   up_valid,
	output logic        up_ready,
	input  wire span_t  up_data,
	output logic        dn_valid,
	input  wire logic   dn_ready,
	output mix_t        dn_data
);

	logic              valid_s3;
	mix_t              data_s3;
	mix_t              next_data;
	logic [FIX_W-1:0]  rise;
	logic [FIX_W-1:0]  fall;
	logic [FIX_W-1:0]  r;
	logic [FIX_W-1:0]  g;
	logic [FIX_W-1:0]  b;

	always_comb begin
		rise = up_data.lo + up_data.ramp;
		fall = up_data.hi - up_data.ramp;
		case (up_data.sector)
			SEC_RED_GREEN_UP: begin
				r = up_data.hi; g = rise;       b = up_data.lo;
			end
			SEC_GREEN_RED_DOWN: begin
				r = fall;       g = up_data.hi; b = up_data.lo;
			end
			SEC_GREEN_BLUE_UP: begin
				r = up_data.lo; g = up_data.hi; b = rise;
			end
			SEC_BLUE_GREEN_DOWN: begin
				r = up_data.lo; g = fall;       b = up_data.hi;
			end
			SEC_BLUE_RED_UP: begin
				r = rise;       g = up_data.lo; b = up_data.hi;
			end
			default: begin
				r = up_data.hi; g = up_data.lo; b = fall;
			end
		endcase
		next_data.r = RED_W'(r >> DIV_SHIFT);
		next_data.g = RED_W'(g >> DIV_SHIFT);
		next_data.b = RED_W'(b >> DIV_SHIFT);
	end

	assign up_ready = !valid_s3 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s3 <= next_data;
		end
	end

	assign dn_valid = valid_s3;
	assign dn_data  = data_s3;

endmodule : hsvrgb_mix
`default_nettype wire

// ===== rtl/hsvrgb_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsvrgb_scale
// stage 4: divides each channel by 9375 through an exact reciprocal product
// ----------------------------------------------------------------------------
module hsvrgb_scale
	import hsvrgb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  up_valid,
	output logic       up_ready,
	input  wire mix_t  up_data,
	output logic       dn_valid,
	input  wire logic  dn_ready,
	output rgb_t       dn_data
);

	logic              valid_s4;
	rgb_t              data_s4;
	rgb_t              next_data;
	logic [MUL_W-1:0]  pr;
	logic [MUL_W-1:0]  pg;
	logic [MUL_W-1:0]  pb;

	always_comb begin
		pr = MUL_W'(up_data.r) * MUL_W'(RECIP_M);
		pg = MUL_W'(up_data.g) * MUL_W'(RECIP_M);
		pb = MUL_W'(up_data.b) * MUL_W'(RECIP_M);
		next_data.red   = pr[RECIP_SHIFT +: CHAN_W];
		next_data.green = pg[RECIP_SHIFT +: CHAN_W];
		next_data.blue  = pb[RECIP_SHIFT +: CHAN_W];
	end

	assign up_ready = !valid_s4 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (up_ready) begin
			valid_s4 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s4 <= next_data;
		end
	end

	assign dn_valid = valid_s4;
	assign dn_data  = data_s4;

endmodule : hsvrgb_scale
`default_nettype wire

// ===== dv/hsv_to_rgb_pixel_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_unit_tb
// self-checking bench for the hsv to rgb pixel unit: directed corner pixels,
// then random pixels with random gaps and stalls on both channels, a
// streaming run with no gaps, a drain pause, and out-of-range hue and
// percent values; every result is compared against an integer color model
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_unit_tb;
	import hsvrgb_pkg::*;

	localparam bit [31:0] PCT_CAP    = 32'd100;
	localparam bit [31:0] HUE_SPAN   = 32'd60;
	localparam bit [31:0] FULL_SCALE = 32'd1530000;
	localparam bit [31:0] DARK_SCALE = 32'd15300;
	localparam bit [31:0] RAMP_STEP  = 32'd255;
	localparam bit [31:0] CHAN_UNIT  = 32'd600000;
	localparam int unsigned STALL_LIMIT  = 1000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned REPORT_MAX   = 10;

	typedef struct {
		logic [8:0] hue;
		logic [6:0] sat;
		logic [6:0] bri;
		rgb_t       rgb;
	} pixel_expect_t;

	logic clk = 1'b0;
	logic arst_n;

	hsvrgb_in_if  in_ch ();
	hsvrgb_out_if out_ch ();

	hsv_to_rgb_pixel_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_ch),
		.out_item (out_ch)
	);

	always #1 clk = ~clk;

	pixel_expect_t rgb_pending[$];
	bit            no_idle = 1'b0;
	int unsigned   pixels_sent = 0;
	int unsigned   pixels_checked = 0;
	int unsigned   error_count = 0;

	function automatic rgb_t pixel_rgb(input logic [8:0] hue, input logic [6:0] sat,
			input logic [6:0] bri);
		bit [31:0] s, v, seg, offs, hi, lo, ramp, up, down, r, g, b;
		sector_t   sec;
		rgb_t      px;
		s    = (sat > PCT_CAP) ? PCT_CAP : 32'(sat);
		v    = (bri > PCT_CAP) ? PCT_CAP : 32'(bri);
		seg  = 32'(hue) / HUE_SPAN;
		offs = 32'(hue) % HUE_SPAN;
		sec  = (seg > SEC_RED_BLUE_DOWN) ? SEC_RED_BLUE_DOWN : sector_t'(seg[2:0]);
		hi   = v * FULL_SCALE;
		lo   = v * DARK_SCALE * (PCT_CAP - s);
		ramp = v * RAMP_STEP * s * offs;
		up   = lo + ramp;
		down = hi - ramp;
		case (sec)
			SEC_RED_GREEN_UP: begin r = hi; g = up; b = lo; end
			SEC_GREEN_RED_DOWN: begin r = down; g = hi; b = lo; end
			SEC_GREEN_BLUE_UP: begin r = lo; g = hi; b = up; end
			SEC_BLUE_GREEN_DOWN: begin r = lo; g = down; b = hi; end
			SEC_BLUE_RED_UP: begin r = up; g = lo; b = hi; end
			default: begin r = hi; g = lo; b = down; end
		endcase
		px.red   = 8'(r / CHAN_UNIT);
		px.green = 8'(g / CHAN_UNIT);
		px.blue  = 8'(b / CHAN_UNIT);
		return px;
	endfunction

	function automatic logic [8:0] rand_hue();
		return ($urandom_range(0, 99) < 85) ? 9'($urandom_range(0, 359))
			: 9'($urandom_range(0, 511));
	endfunction

	function automatic logic [6:0] rand_pct();
		return ($urandom_range(0, 99) < 80) ? 7'($urandom_range(0, 100))
			: 7'($urandom_range(0, 127));
	endfunction

	task automatic send_pixel(input logic [8:0] hue, input logic [6:0] sat,
			input logic [6:0] bri);
		int unsigned   gap;
		pixel_expect_t want;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.hue        <= hue;
		in_ch.saturation <= sat;
		in_ch.brightness <= bri;
		do @(posedge clk); while (!in_ch.ready);
		want.hue = hue;
		want.sat = sat;
		want.bri = bri;
		want.rgb = pixel_rgb(hue, sat, bri);
		rgb_pending.push_back(want);
		pixels_sent++;
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (rgb_pending.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_corner_pixels();
		logic [8:0] hues [22];
		logic [6:0] sats [22];
		logic [6:0] bris [22];
		hues = '{0, 0, 0, 59, 60, 120, 180, 240, 300, 359, 360,
			419, 420, 511, 30, 90, 150, 210, 270, 330, 256, 45};
		sats = '{0, 0, 100, 100, 100, 100, 100, 100, 100, 100, 100,
			100, 77, 127, 101, 127, 50, 1, 99, 64, 0, 37};
		bris = '{0, 100, 100, 100, 100, 100, 100, 100, 100, 100, 100,
			100, 63, 127, 50, 101, 127, 1, 99, 64, 127, 100};
		for (int i = 0; i < 22; i++)
			send_pixel(hues[i], sats[i], bris[i]);
	endtask

	task automatic test_random_pixels(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_pixel(rand_hue(), rand_pct(), rand_pct());
	endtask

	task automatic test_streaming_pixels(input int unsigned count);
		no_idle = 1'b1;
		for (int unsigned i = 0; i < count; i++)
			send_pixel(rand_hue(), rand_pct(), rand_pct());
		no_idle = 1'b0;
	endtask

	task automatic test_drain_pause(input int unsigned rounds, input int unsigned burst);
		for (int unsigned k = 0; k < rounds; k++) begin
			for (int unsigned i = 0; i < burst; i++)
				send_pixel(rand_hue(), rand_pct(), rand_pct());
			wait_drained();
		end
	endtask

	task automatic test_out_of_range_pixels(input int unsigned count);
		logic [8:0] hue;
		logic [6:0] sat;
		logic [6:0] bri;
		for (int unsigned i = 0; i < count; i++) begin
			hue = $urandom_range(0, 1) ? 9'($urandom_range(360, 511)) : rand_hue();
			sat = $urandom_range(0, 1) ? 7'($urandom_range(101, 127)) : rand_pct();
			bri = $urandom_range(0, 1) ? 7'($urandom_range(101, 127)) : rand_pct();
			send_pixel(hue, sat, bri);
		end
	endtask

	// result side: random stalls, then compare against the oldest expectation
	initial begin : result_checker
		int unsigned   stall;
		int unsigned   reported;
		pixel_expect_t want;
		rgb_t          got;
		reported = 0;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			got.red   = out_ch.red;
			got.green = out_ch.green;
			got.blue  = out_ch.blue;
			if (rgb_pending.size() == 0) begin
				error_count++;
				if (reported < REPORT_MAX) begin
					reported++;
					$display("unexpected result r=%0d g=%0d b=%0d at %0t",
						got.red, got.green, got.blue, $realtime);
				end
			end else begin
				want = rgb_pending.pop_front();
				pixels_checked++;
				if (got.red !== want.rgb.red || got.green !== want.rgb.green
						|| got.blue !== want.rgb.blue) begin
					error_count++;
					if (reported < REPORT_MAX) begin
						reported++;
						$display("mismatch h=%0d s=%0d v=%0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
							want.hue, want.sat, want.bri,
							want.rgb.red, want.rgb.green, want.rgb.blue,
							got.red, got.green, got.blue);
					end
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n           <= 1'b0;
		in_ch.valid      <= 1'b0;
		in_ch.hue        <= '0;
		in_ch.saturation <= '0;
		in_ch.brightness <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_pixels();
		test_random_pixels(650);
		test_streaming_pixels(220);
		test_drain_pause(4, 40);
		test_out_of_range_pixels(300);

		in_ch.valid <= 1'b0;
		while (rgb_pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		error_count += rgb_pending.size();

		$display("converted %0d pixels over all six sectors, hue up to 511, percents up to 127",
			pixels_sent);
		$display("checked %0d results under random gaps, stalls and a drain pause; %0d errors",
			pixels_checked, error_count);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule : hsv_to_rgb_pixel_unit_tb
